[hw/rtl/kss_pkg.sv]
// shared types and constants for the k-sorted stream sorter
package kss_pkg;

    localparam int DATA_W = 32;
    localparam int KREG_W = 5;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index taken from paddr[2]
    localparam logic REG_WINDOW_K = 1'b0;

    // commands from controller to datapath
    typedef struct packed {
        logic insert;
        logic pop;
        logic drain;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic over_k;
        logic last_one;
        logic out_free;
    } t_dp_status;

endpackage

[hw/rtl/k_sorted_stream_sorter.sv]
// Sorter for k-sorted streams of signed 32-bit words. Each accepted word is
// inserted into an ascending window of K_MAX+2 registers; then, if the
// window holds more than min(window_k, K_MAX)+1 words, its minimum moves to
// the output register once that register is free. A word with last is
// inserted and then the whole window drains, lowest first, the final word
// flagged with run_end and array_end. The window row does one insert or one
// removal per cycle; removals, in the check and drain steps, wait while the
// output register is stalled. The input accepts a new word while a result
// still waits in the output register.
// window_k sits at APB address 0 and should be written only while idle.
module k_sorted_stream_sorter import kss_pkg::*; #(
    parameter int K_MAX = 31
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_run_end,
    output logic                     o_array_end
);

    logic [KREG_W-1:0] r_window_k;
    t_dp_cmd           w_cmd;
    t_dp_status        w_status;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW_K) ? APB_DW'(r_window_k) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_k <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_WINDOW_K)) begin
            r_window_k <= pwdata[KREG_W-1:0];
        end
    end

    // controller
    kss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // datapath
    kss_datapath #(
        .K_MAX (K_MAX)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_value        (i_value),
        .i_window_k     (r_window_k),
        .i_out_stall    (i_out_stall),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_sorted_value (o_sorted_value),
        .o_run_end      (o_run_end),
        .o_array_end    (o_array_end)
    );

`ifndef SYNTHESIS
    a_insert_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.insert && w_cmd.pop))
        else $error("insert and pop issued together");

    a_pop_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |-> w_status.out_free)
        else $error("pop while output register is held");

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("word accepted on consecutive cycles");

    a_array_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_array_end) |-> o_run_end)
        else $error("array end without run end");
`endif

endmodule

[hw/rtl/kss_ctrl.sv]
// controller state machine: accept, emit check and drain sequencing
module kss_ctrl import kss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_last,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state      = r_state;
        o_cmd.insert = 1'b0;
        o_cmd.pop    = 1'b0;
        o_cmd.drain  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.insert = 1'b1;
                    n_state      = i_last ? ST_DRAIN : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_status.over_k) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.pop = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                o_cmd.drain = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.pop = 1'b1;
                    if (i_status.last_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/kss_datapath.sv]
// datapath: sorted window register row, fill count and output word register
module kss_datapath import kss_pkg::*; #(
    parameter int K_MAX = 31
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [KREG_W-1:0]        i_window_k,
    input  logic                     i_out_stall,
    output t_dp_status               o_status,
    output logic                     o_out_valid,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_run_end,
    output logic                     o_array_end
);

    localparam int DEPTH = K_MAX + 2;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int TW    = ((CW > KREG_W) ? CW : KREG_W) + 1;

    logic signed [DATA_W-1:0] r_win [DEPTH];
    logic signed [DATA_W-1:0] n_win [DEPTH];
    logic [DEPTH-1:0]         w_gt;
    logic [CW-1:0]            r_count;
    logic [TW-1:0]            w_k_ext;
    logic [TW-1:0]            w_effk;
    logic [TW-1:0]            w_thr;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_run_end;
    logic                     r_out_array_end;
    logic                     w_fin;

    // effective k saturates at K_MAX; emit when count exceeds k+1
    assign w_k_ext = TW'(i_window_k);
    assign w_effk  = (w_k_ext > TW'(K_MAX)) ? TW'(K_MAX) : w_k_ext;
    assign w_thr   = w_effk + TW'(1);

    assign o_status.over_k   = (TW'(r_count) > w_thr);
    assign o_status.last_one = (r_count == CW'(1));
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // insertion: entries above the new value and empty slots shift up by one
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_gt[i] = (CW'(i) >= r_count) || (r_win[i] > i_value);
        end
        n_win[0] = w_gt[0] ? i_value : r_win[0];
        for (int i = 1; i < DEPTH; i++) begin
            if (!w_gt[i]) begin
                n_win[i] = r_win[i];
            end else if (w_gt[i-1]) begin
                n_win[i] = r_win[i-1];
            end else begin
                n_win[i] = i_value;
            end
        end
    end

    // window row: insert or pop the minimum
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_win[i] <= n_win[i];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.insert) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.pop) begin
            r_count <= r_count - CW'(1);
        end
    end

    // output word register
    assign w_fin = i_cmd.drain && (r_count == CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_out_value     <= r_win[0];
            r_out_run_end   <= !i_cmd.drain || w_fin;
            r_out_array_end <= w_fin;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_run_end      = r_out_run_end;
    assign o_array_end    = r_out_array_end;

endmodule
